>>> design/frls_pkg.sv
package frls_pkg;

    localparam int PAGE_BYTES_DEF = 512;
    localparam int MAX_PAGES_DEF  = 4;
    localparam int MAX_RECORD_DEF = 64;
    localparam int MIN_RECORD     = 4;

    localparam int SIZE_W  = 7;
    localparam int PAGES_W = 3;
    localparam int POS_W   = 6;
    localparam int SI_W    = 10;
    localparam int BYTE_W  = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [SIZE_W-1:0]  SIZE_RST  = 7'd16;
    localparam logic [PAGES_W-1:0] PAGES_RST = 3'd1;

    // register index is paddr[2]
    localparam logic REG_SIZE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    localparam logic ACT_SAVE  = 1'b0;
    localparam logic ACT_READ  = 1'b1;
    localparam logic KIND_SAVE = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_ERR  = 1'b1;

    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

    // bytes of a slot header that mark it empty
    localparam int SCAN_LEN = 4;

endpackage

>>> design/frls_flash_mem.sv
module frls_flash_mem import frls_pkg::*; #(
    parameter int DEPTH = PAGE_BYTES_DEF * MAX_PAGES_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/frls_slot_div.sv
module frls_slot_div import frls_pkg::*; #(
    parameter int N_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_W-1:0]    i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [N_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [N_W-1:0]    r_num, n_num;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W:0]   trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_num[N_W-1]};
        n_cnt = r_cnt;
        n_num = r_num;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = CNT_W'(N_W);
            n_num = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = SIZE_W'(trial - {1'b0, i_divisor});
                n_num = {r_num[N_W-2:0], 1'b1};
            end else begin
                n_rem = SIZE_W'(trial);
                n_num = {r_num[N_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_num;

endmodule

>>> design/frls_cfg.sv
module frls_cfg import frls_pkg::*; #(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int MAX_RECORD = MAX_RECORD_DEF,
    localparam int PG_W = $clog2(MAX_PAGES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready,
    output logic [SIZE_W-1:0] o_size,
    output logic [PG_W-1:0]   o_pages,
    output logic              o_wr
);

    logic [SIZE_W-1:0]  r_size;
    logic [PAGES_W-1:0] r_pages;
    logic               wr;

    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RST;
            r_pages <= PAGES_RST;
        end else if (wr) begin
            case (i_paddr[2])
                REG_SIZE:  r_size  <= i_pwdata[SIZE_W-1:0];
                REG_PAGES: r_pages <= i_pwdata[PAGES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_size < SIZE_W'(MIN_RECORD)) begin
            o_size = SIZE_W'(MIN_RECORD);
        end else if (r_size > SIZE_W'(MAX_RECORD)) begin
            o_size = SIZE_W'(MAX_RECORD);
        end else begin
            o_size = r_size;
        end
    end

    always_comb begin
        if (r_pages == '0) begin
            o_pages = PG_W'(1);
        end else if ({{PG_W{1'b0}}, r_pages} > (PG_W + PAGES_W)'(MAX_PAGES)) begin
            o_pages = PG_W'(MAX_PAGES);
        end else begin
            o_pages = PG_W'(r_pages);
        end
    end

    assign o_prdata = (i_paddr[2] == REG_PAGES) ? APB_DW'(r_pages) : APB_DW'(r_size);
    assign o_pready = 1'b1;
    assign o_wr     = wr;

endmodule

>>> design/frls_ctrl.sv
module frls_ctrl import frls_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    localparam int STORE_BYTES = PAGE_BYTES * MAX_PAGES,
    localparam int ADDR_W = $clog2(STORE_BYTES),
    localparam int REG_W  = $clog2(STORE_BYTES + 1),
    localparam int PG_W   = $clog2(MAX_PAGES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_busy,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [PG_W-1:0]   i_pages,
    input  logic              i_cfg_wr,
    output logic              o_div_start,
    output logic [REG_W-1:0]  o_div_num,
    input  logic              i_div_busy,
    input  logic [REG_W-1:0]  i_slots,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [BYTE_W-1:0] o_wdata,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [BYTE_W-1:0] i_rdata,
    output logic              o_strobe,
    output logic              o_result_kind,
    output logic [BYTE_W-1:0] o_record_byte,
    output logic              o_byte_last,
    output logic              o_status
);

    localparam int SA_W = SI_W + SIZE_W;
    localparam int CW   = SI_W + REG_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV       = 4'd1;
    localparam logic [3:0] S_ERASE     = 4'd2;
    localparam logic [3:0] S_SAVE_WR   = 4'd3;
    localparam logic [3:0] S_SCAN      = 4'd4;
    localparam logic [3:0] S_SCAN_DEC  = 4'd5;
    localparam logic [3:0] S_CHECK     = 4'd6;
    localparam logic [3:0] S_CHECK_DEC = 4'd7;
    localparam logic [3:0] S_STREAM    = 4'd8;
    localparam logic [3:0] S_ZEROS     = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [SI_W-1:0]   r_slot_idx, n_slot_idx;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_chk, n_chk;
    logic [BYTE_W-1:0] r_pend, n_pend;
    logic              r_div_req, n_div_req;
    logic [ADDR_W-1:0] r_ecnt, n_ecnt;
    logic [REG_W-1:0]  r_eend, n_eend;
    logic              r_eret, n_eret;
    logic [REG_W-1:0]  r_blk, n_blk;
    logic [REG_W-1:0]  r_base, n_base;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic              r_acc, n_acc;
    logic [BYTE_W-1:0] r_vchk, n_vchk;
    logic              r_rd_v, n_rd_v;
    logic [POS_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_bad, n_bad;
    logic              r_em_v, n_em_v;
    logic              r_em_kind, n_em_kind;
    logic              r_em_last, n_em_last;
    logic              r_em_st, n_em_st;
    logic              r_em_mem, n_em_mem;

    logic              r_strobe;
    logic              r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_stat;

    logic [REG_W-1:0]  region;
    logic [SIZE_W-1:0] size_m1;
    logic [BYTE_W-1:0] sv_b;
    logic [SA_W-1:0]   sv_addr;
    logic              sv_end;
    logic              sv_inrange;
    logic [BYTE_W-1:0] sv_chk;
    logic              need_erase;
    logic              save_go;
    logic              cnt_last;
    logic              empty;

    assign region  = REG_W'(i_pages) * REG_W'(PAGE_BYTES);
    assign size_m1 = i_size - 1'b1;

    assign sv_b       = (r_state == S_SAVE_WR) ? r_pend : i_data_byte;
    assign sv_addr    = SA_W'(r_slot_idx) * SA_W'(i_size) + SA_W'(r_pos);
    assign sv_end     = ({1'b0, r_pos} >= size_m1);
    assign sv_inrange = (sv_addr < SA_W'(STORE_BYTES));
    assign sv_chk     = (r_pos == '0) ? sv_b : (r_chk - 8'd1 - sv_b);
    assign need_erase = (r_pos == '0) && (CW'(r_slot_idx) >= (CW'(i_slots) - CW'(1)));
    assign cnt_last   = ({1'b0, r_cnt} == size_m1);
    assign empty      = r_acc && (i_rdata == ERASED_BYTE);

    assign o_raddr   = ADDR_W'(r_base + REG_W'(r_cnt));
    assign o_div_num = region;
    assign o_busy    = (r_state != S_IDLE) || r_div_req;

    always_comb begin
        n_state    = r_state;
        n_slot_idx = r_slot_idx;
        n_pos      = r_pos;
        n_chk      = r_chk;
        n_pend     = r_pend;
        n_div_req  = r_div_req | i_cfg_wr;
        n_ecnt     = r_ecnt;
        n_eend     = r_eend;
        n_eret     = r_eret;
        n_blk      = r_blk;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_vchk     = r_vchk;
        n_rd_v     = 1'b0;
        n_rd_idx   = r_cnt;
        n_bad      = r_bad;
        n_em_v     = 1'b0;
        n_em_kind  = KIND_READ;
        n_em_last  = 1'b0;
        n_em_st    = STAT_OK;
        n_em_mem   = 1'b0;
        o_div_start = 1'b0;
        o_we       = 1'b0;
        o_waddr    = ADDR_W'(sv_addr);
        o_wdata    = sv_end ? r_chk : sv_b;
        save_go    = 1'b0;

        // check byte accumulation over the read-back beats
        if (r_rd_v && (r_state == S_CHECK || r_state == S_CHECK_DEC)) begin
            if (r_rd_idx == '0) begin
                n_vchk = i_rdata;
            end else if ({1'b0, r_rd_idx} < size_m1) begin
                n_vchk = r_vchk - 8'd1 - i_rdata;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (r_div_req) begin
                    o_div_start = 1'b1;
                    n_div_req   = i_cfg_wr;
                    n_state     = S_DIV;
                end else if (i_start) begin
                    if (i_action == ACT_READ) begin
                        n_pos   = '0;
                        n_chk   = '0;
                        n_blk   = '0;
                        n_base  = '0;
                        n_cnt   = '0;
                        n_state = S_SCAN;
                    end else if (need_erase) begin
                        n_pend     = i_data_byte;
                        n_slot_idx = '0;
                        n_ecnt     = '0;
                        n_eend     = region;
                        n_eret     = 1'b1;
                        n_state    = S_ERASE;
                    end else begin
                        save_go = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (!i_div_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_ERASE: begin
                o_we    = 1'b1;
                o_waddr = r_ecnt;
                o_wdata = ERASED_BYTE;
                n_ecnt  = r_ecnt + 1'b1;
                if (REG_W'(r_ecnt) == r_eend - 1'b1) begin
                    n_state = r_eret ? S_SAVE_WR : S_IDLE;
                end
            end
            S_SAVE_WR: begin
                save_go = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                n_rd_v = 1'b1;
                if (r_cnt == '0) begin
                    n_acc = 1'b1;
                end else if (r_rd_v) begin
                    n_acc = r_acc && (i_rdata == ERASED_BYTE);
                end
                if (r_cnt == POS_W'(SCAN_LEN - 1)) begin
                    n_state = S_SCAN_DEC;
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_SCAN_DEC: begin
                n_cnt = '0;
                if (empty) begin
                    if (r_blk == '0) begin
                        n_bad   = 1'b0;
                        n_state = S_ZEROS;
                    end else begin
                        n_base  = r_base - REG_W'(i_size);
                        n_state = S_CHECK;
                    end
                end else if (r_blk + 1'b1 >= i_slots) begin
                    n_blk   = r_blk + 1'b1;
                    n_state = S_CHECK;
                end else begin
                    n_blk   = r_blk + 1'b1;
                    n_base  = r_base + REG_W'(i_size);
                    n_state = S_SCAN;
                end
            end
            S_CHECK: begin
                n_rd_v = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = S_CHECK_DEC;
                end
            end
            S_CHECK_DEC: begin
                n_cnt = '0;
                if (r_vchk == i_rdata) begin
                    n_state = S_STREAM;
                end else begin
                    n_bad      = 1'b1;
                    n_slot_idx = '0;
                    n_state    = S_ZEROS;
                end
            end
            S_STREAM: begin
                n_em_v    = 1'b1;
                n_em_mem  = 1'b1;
                n_em_last = cnt_last;
                n_cnt     = r_cnt + 1'b1;
                if (cnt_last) begin
                    if (r_blk >= i_slots) begin
                        n_slot_idx = '0;
                        n_ecnt     = '0;
                        n_eend     = region;
                        n_eret     = 1'b0;
                        n_state    = S_ERASE;
                    end else begin
                        n_slot_idx = SI_W'(r_blk);
                        n_state    = S_IDLE;
                    end
                end
            end
            S_ZEROS: begin
                n_em_v    = 1'b1;
                n_em_st   = STAT_ERR;
                n_em_last = cnt_last;
                n_cnt     = r_cnt + 1'b1;
                if (cnt_last) begin
                    if (r_bad) begin
                        n_ecnt  = '0;
                        n_eend  = region;
                        n_eret  = 1'b0;
                        n_state = S_ERASE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (save_go) begin
            o_we = sv_inrange;
            if (sv_end) begin
                n_slot_idx = r_slot_idx + 1'b1;
                n_pos      = '0;
                n_chk      = '0;
                n_em_v     = 1'b1;
                n_em_kind  = KIND_SAVE;
                n_em_last  = 1'b1;
                n_em_st    = STAT_OK;
            end else begin
                n_pos = r_pos + 1'b1;
                n_chk = sv_chk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_ERASE;
            r_slot_idx <= '0;
            r_pos      <= '0;
            r_chk      <= '0;
            r_div_req  <= 1'b1;
            r_ecnt     <= '0;
            r_eend     <= REG_W'(STORE_BYTES);
            r_eret     <= 1'b0;
            r_rd_v     <= 1'b0;
            r_em_v     <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot_idx <= n_slot_idx;
            r_pos      <= n_pos;
            r_chk      <= n_chk;
            r_div_req  <= n_div_req;
            r_ecnt     <= n_ecnt;
            r_eend     <= n_eend;
            r_eret     <= n_eret;
            r_rd_v     <= n_rd_v;
            r_em_v     <= n_em_v;
            r_strobe   <= r_em_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend    <= n_pend;
        r_blk     <= n_blk;
        r_base    <= n_base;
        r_cnt     <= n_cnt;
        r_acc     <= n_acc;
        r_vchk    <= n_vchk;
        r_rd_idx  <= n_rd_idx;
        r_bad     <= n_bad;
        r_em_kind <= n_em_kind;
        r_em_last <= n_em_last;
        r_em_st   <= n_em_st;
        r_em_mem  <= n_em_mem;
        r_kind    <= r_em_kind;
        r_byte    <= r_em_mem ? i_rdata : '0;
        r_last    <= r_em_last;
        r_stat    <= r_em_st;
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_record_byte = r_byte;
    assign o_byte_last   = r_last;
    assign o_status      = r_stat;

endmodule

>>> design/flash_record_log_store.sv
// Save beat: one per cycle while busy is low; the status result of the record's last beat
// goes through r_em_v and then r_strobe. A first save beat on a full log first erases the
// region (one byte a cycle). Read: a scan of slot headers, a check of the latest slot and a
// stream of it, results via r_em_v and r_strobe; a failed check or a wrapped log adds a region
// erase. Reset: busy for a clearing pass of the whole store, then a slot count division; every
// config write reruns the division. Results cannot be stalled by the receiver.
module flash_record_log_store import frls_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int MAX_RECORD = MAX_RECORD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_strobe,
    output logic              o_result_kind,
    output logic [BYTE_W-1:0] o_record_byte,
    output logic              o_byte_last,
    output logic              o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int STORE_BYTES = PAGE_BYTES * MAX_PAGES;
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int REG_W  = $clog2(STORE_BYTES + 1);
    localparam int PG_W   = $clog2(MAX_PAGES + 1);

    logic [SIZE_W-1:0] eff_size;
    logic [PG_W-1:0]   eff_pages;
    logic              cfg_wr;
    logic              div_start;
    logic              div_busy;
    logic [REG_W-1:0]  div_num;
    logic [REG_W-1:0]  slots;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [BYTE_W-1:0] rdata;

    frls_cfg #(
        .MAX_PAGES  (MAX_PAGES),
        .MAX_RECORD (MAX_RECORD)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_size    (eff_size),
        .o_pages   (eff_pages),
        .o_wr      (cfg_wr)
    );

    frls_slot_div #(
        .N_W (REG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (eff_size),
        .o_busy     (div_busy),
        .o_quot     (slots)
    );

    frls_flash_mem #(
        .DEPTH (STORE_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    frls_ctrl #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .o_busy        (busy),
        .i_size        (eff_size),
        .i_pages       (eff_pages),
        .i_cfg_wr      (cfg_wr),
        .o_div_start   (div_start),
        .o_div_num     (div_num),
        .i_div_busy    (div_busy),
        .i_slots       (slots),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_record_byte (o_record_byte),
        .o_byte_last   (o_byte_last),
        .o_status      (o_status)
    );

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frls_pkg::*;

    localparam int STORE_BYTES = PAGE_BYTES_DEF * MAX_PAGES_DEF;
    localparam int CYCLE_LIMIT = 10_000_000;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] data;
    } t_beat;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] rbyte;
        logic              last;
        logic              status;
    } t_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_action = ACT_SAVE;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              o_strobe;
    logic              o_result_kind;
    logic [BYTE_W-1:0] o_record_byte;
    logic              o_byte_last;
    logic              o_status;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    flash_record_log_store uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // log model state
    logic [BYTE_W-1:0]  flash_img [STORE_BYTES];
    logic [SI_W-1:0]    slot_ptr;
    logic [POS_W-1:0]   save_pos;
    logic [BYTE_W-1:0]  chk_acc;
    logic [SIZE_W-1:0]  size_reg;
    logic [PAGES_W-1:0] pages_reg;

    t_beat pending_beats[$];
    t_res  due_results[$];
    int    queued_cnt = 0;
    int    taken_cnt = 0;
    int    err_cnt = 0;
    int    gap_pct = 0;
    int    cyc = 0;

    function automatic int rec_len();
        int s;
        s = size_reg;
        if (s < MIN_RECORD) s = MIN_RECORD;
        if (s > MAX_RECORD_DEF) s = MAX_RECORD_DEF;
        return s;
    endfunction

    function automatic int region_pages();
        int p;
        p = pages_reg;
        if (p < 1) p = 1;
        if (p > MAX_PAGES_DEF) p = MAX_PAGES_DEF;
        return p;
    endfunction

    function automatic int slot_total();
        return (PAGE_BYTES_DEF * region_pages()) / rec_len();
    endfunction

    function automatic bit slot_blank(input int base);
        return flash_img[base] == ERASED_BYTE && flash_img[base+1] == ERASED_BYTE &&
               flash_img[base+2] == ERASED_BYTE && flash_img[base+3] == ERASED_BYTE;
    endfunction

    function automatic t_res mk_res(input logic kind, input logic [BYTE_W-1:0] rbyte,
                                    input logic last, input logic status);
        t_res r;
        r.kind = kind;
        r.rbyte = rbyte;
        r.last = last;
        r.status = status;
        return r;
    endfunction

    task automatic wipe_region();
        for (int i = 0; i < PAGE_BYTES_DEF * region_pages(); i++) flash_img[i] = ERASED_BYTE;
    endtask

    task automatic stream_error(input int sz);
        for (int i = 0; i < sz; i++)
            due_results.push_back(mk_res(KIND_READ, '0, i == sz - 1, STAT_ERR));
    endtask

    task automatic log_save_byte(input logic [BYTE_W-1:0] b);
        int sz, nslots, pos, addr;
        sz = rec_len();
        nslots = slot_total();
        pos = save_pos;
        if (pos == 0) begin
            if (slot_ptr >= nslots - 1) begin
                wipe_region();
                slot_ptr = '0;
            end
            chk_acc = b;
        end else if (pos < sz - 1) begin
            chk_acc = chk_acc - 8'd1 - b;
        end
        addr = slot_ptr * sz + pos;
        if (pos >= sz - 1) begin
            if (addr < STORE_BYTES) flash_img[addr] = chk_acc;
            slot_ptr = slot_ptr + 1'b1;
            save_pos = '0;
            chk_acc = '0;
            due_results.push_back(mk_res(KIND_SAVE, '0, 1'b1, STAT_OK));
        end else begin
            if (addr < STORE_BYTES) flash_img[addr] = b;
            save_pos = POS_W'(pos + 1);
        end
    endtask

    task automatic log_read_latest();
        int sz, nslots, blk, base;
        logic [BYTE_W-1:0] c;
        sz = rec_len();
        nslots = slot_total();
        save_pos = '0;
        chk_acc = '0;
        blk = 0;
        while (blk < nslots && !slot_blank(blk * sz)) blk++;
        if (blk == 0) begin
            stream_error(sz);
            return;
        end
        base = (blk - 1) * sz;
        c = flash_img[base];
        for (int i = 1; i + 1 < sz; i++) c = c - 8'd1 - flash_img[base+i];
        if (c != flash_img[base+sz-1]) begin
            wipe_region();
            slot_ptr = '0;
            stream_error(sz);
            return;
        end
        for (int i = 0; i < sz; i++)
            due_results.push_back(mk_res(KIND_READ, flash_img[base+i], i == sz - 1, STAT_OK));
        slot_ptr = SI_W'(blk);
        if (blk >= nslots) begin
            wipe_region();
            slot_ptr = '0;
        end
    endtask

    task automatic note_bad(input string what, input t_res want, input t_res got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t %s: exp kind=%0d byte=%02h last=%0d status=%0d, %s",
                     $realtime, what, want.kind, want.rbyte, want.last, want.status,
                     $sformatf("got kind=%0d byte=%02h last=%0d status=%0d",
                               got.kind, got.rbyte, got.last, got.status));
    endtask

    // driver: one beat per accepted start
    always @(posedge i_clk) begin : drv_blk
        t_beat nb;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (i_action == ACT_READ) log_read_latest();
                else log_save_byte(i_data_byte);
                taken_cnt++;
            end
            if (!start || !busy) begin
                if (pending_beats.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    nb = pending_beats.pop_front();
                    start <= 1'b1;
                    i_action <= nb.action;
                    i_data_byte <= nb.data;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : mon_blk
        t_res got, want;
        if (i_rst_n && o_strobe) begin
            got = mk_res(o_result_kind, o_record_byte, o_byte_last, o_status);
            if (due_results.size() == 0) begin
                note_bad("result with nothing pending", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got !== want) note_bad("result mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin : limit_blk
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic settle();
        do @(posedge i_clk);
        while (taken_cnt != queued_cnt || due_results.size() != 0);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_SIZE) size_reg = val[SIZE_W-1:0];
        else pages_reg = val[PAGES_W-1:0];
        settle();
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return ERASED_BYTE;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic push_beat(input logic act, input logic [BYTE_W-1:0] data);
        t_beat b;
        b.action = act;
        b.data = data;
        pending_beats.push_back(b);
        queued_cnt++;
    endtask

    task automatic queue_record(input int sz, input bit blank_head);
        for (int i = 0; i < sz; i++)
            push_beat(ACT_SAVE, (blank_head && i < SCAN_LEN) ? ERASED_BYTE : rand_byte());
    endtask

    // mostly whole records, with reads, cut-off records and stray beats mixed in
    task automatic queue_mix(input int n);
        int added, sz, k, sel;
        sz = rec_len();
        added = 0;
        while (added < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 62) begin
                queue_record(sz, $urandom_range(0, 9) == 0);
                added += sz;
            end else if (sel < 82) begin
                push_beat(ACT_READ, BYTE_W'($urandom));
                added++;
            end else if (sel < 94) begin
                k = $urandom_range(1, sz - 1);
                for (int i = 0; i < k; i++) push_beat(ACT_SAVE, rand_byte());
                added += k;
            end else begin
                push_beat(1'($urandom_range(0, 1)), rand_byte());
                added++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < STORE_BYTES; i++) flash_img[i] = ERASED_BYTE;
        slot_ptr = '0;
        save_pos = '0;
        chk_acc = '0;
        size_reg = SIZE_RST;
        pages_reg = PAGES_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        gap_pct = 33;
        cfg_write(REG_SIZE, 32'd16);
        cfg_write(REG_PAGES, 32'd1);
        push_beat(ACT_READ, 8'h00);
        for (int i = 0; i < 16; i++) push_beat(ACT_SAVE, i[0] ? 8'hFF : 8'h00);
        push_beat(ACT_READ, ERASED_BYTE);
        // abandoned save leaves a broken slot behind, next read fails its check
        push_beat(ACT_SAVE, 8'h5A);
        push_beat(ACT_SAVE, 8'h00);
        push_beat(ACT_SAVE, ERASED_BYTE);
        push_beat(ACT_READ, 8'h00);
        push_beat(ACT_READ, 8'h00);
        queue_record(16, 1'b1);
        push_beat(ACT_READ, 8'h00);
        queue_mix(12);
        settle();

        gap_pct = 87;
        cfg_write(REG_SIZE, 32'd4);
        cfg_write(REG_PAGES, 32'd4);
        queue_mix(12);
        for (int i = 0; i < 8; i++) queue_record(4, 1'b0);
        settle();

        // slot pointer is now past the smaller region: first save erases
        gap_pct = 0;
        cfg_write(REG_SIZE, ($urandom & 32'hFFFF_FF80) | 32'd127);
        cfg_write(REG_PAGES, 32'd1);
        queue_record(64, 1'b0);
        push_beat(ACT_READ, BYTE_W'($urandom));
        settle();

        // a zero page count saturates to one page
        cfg_write(REG_PAGES, $urandom & 32'hFFFF_FFF8);
        push_beat(ACT_READ, BYTE_W'($urandom));
        settle();

        cfg_write(REG_SIZE, 32'd60);
        for (int i = 0; i < 24; i++) push_beat(ACT_SAVE, rand_byte());
        settle();

        // size drops below the open record's position
        cfg_write(REG_SIZE, $urandom & 32'hFFFF_FF80);
        cfg_write(REG_PAGES, 32'd7);
        queue_mix(20);
        settle();

        if (err_cnt == 0 && due_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
design/frls_pkg.sv
design/frls_flash_mem.sv
design/frls_slot_div.sv
design/frls_cfg.sv
design/frls_ctrl.sv
design/flash_record_log_store.sv
tb/sv/tb.sv
